[hw/rtl/sam_pkg.sv]
// ----------------------------------------------------------------------------
// sam_pkg - shared types and codes of the syscall automaton monitor
// Request, result, configuration and edge-table layouts, plus their codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

    // request types
    localparam logic [1:0] REQ_EDGE  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_CALL  = 2'd2;

    // edge kinds
    localparam logic [1:0] KIND_UNUSED = 2'd0;
    localparam logic [1:0] KIND_EPS    = 2'd1;
    localparam logic [1:0] KIND_LABEL  = 2'd2;
    localparam logic [1:0] KIND_RESVD  = 2'd3;

    // verdicts
    localparam logic [1:0] V_ACK     = 2'd0;
    localparam logic [1:0] V_ALLOW   = 2'd1;
    localparam logic [1:0] V_VIOL    = 2'd2;
    localparam logic [1:0] V_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START_NODE = 2'd0;
    localparam logic [1:0] CFG_WARMUP     = 2'd1;

    localparam int unsigned LABEL_W = 9;
    localparam int unsigned NODE_W  = 6;
    localparam int unsigned COUNT_W = 7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         edge_slot;
        logic [NODE_W-1:0]  edge_source;
        logic [NODE_W-1:0]  edge_target;
        logic [1:0]         edge_kind;
        logic [LABEL_W-1:0] edge_label;
        logic [LABEL_W-1:0] call_number;
        logic               at_entry;
    } t_req;

    typedef struct packed {
        logic [1:0]         verdict;
        logic               checked;
        logic [COUNT_W-1:0] active_count;
    } t_rsp;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [NODE_W-1:0]  src;
        logic [NODE_W-1:0]  dst;
        logic [LABEL_W-1:0] label;
    } t_edge;

    // control of the shared edge evaluator
    typedef struct packed {
        logic               match_mode;
        logic [LABEL_W-1:0] call;
    } t_eval_ctl;

endpackage

`default_nettype wire

[hw/rtl/sam_stream_if.sv]
// ----------------------------------------------------------------------------
// sam_stream_if - valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sam_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/syscall_automaton_monitor.sv]
// ----------------------------------------------------------------------------
// syscall_automaton_monitor - policy automaton check of system-call events
// Walks an epsilon/labelled edge table with one shared edge evaluator.
// ----------------------------------------------------------------------------
// Edge writes, starts, exits, warm-up entries and events after a violation:
//   result registered at the input transfer, one item per cycle while each result is taken.
// Checked entry: epsilon passes P1, one match scan over the table, epsilon passes P2, node count, result;
//   P1/P2 the epsilon passes before/after the match scan; a violation skips P2 and the count.
// One item at a time: input held while a result waits and is not taken that cycle.
// Reset: edge table swept to unused, one entry per cycle over all EDGE_COUNT entries, input held.
`default_nettype none

module syscall_automaton_monitor #(
    parameter int NODE_COUNT = 64,
    parameter int EDGE_COUNT = 256,
    parameter int CALL_BITS  = 9
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sam_stream_if.sink   i_req,
    sam_stream_if.source o_rsp,
    sam_stream_if.sink   i_cfg
);
    localparam int AW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
    localparam int CW = $clog2(NODE_COUNT);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CLO  = 3'd2;
    localparam logic [2:0] S_MAT  = 3'd3;
    localparam logic [2:0] S_CNT  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // sequencer state
    logic [2:0]            r_state,  n_state;
    logic [AW:0]           r_idx,    n_idx;
    logic                  r_grew,   n_grew;
    logic                  r_phase2, n_phase2;
    logic                  r_hit,    n_hit;
    logic [NODE_COUNT-1:0] r_set,    n_set;
    logic [NODE_COUNT-1:0] r_next,   n_next;
    logic [NODE_COUNT-1:0] r_active, n_active;
    logic [CW-1:0]         r_cidx,   n_cidx;
    logic [6:0]            r_acc,    n_acc;
    logic [6:0]            r_count,  n_count;
    logic [7:0]            r_ecnt,   n_ecnt;
    logic                  r_viol,   n_viol;
    logic [1:0]            r_pv,     n_pv;
    logic [8:0]            r_call,   n_call;
    // configuration
    logic [5:0]            r_start,  n_start;
    logic [7:0]            r_warm,   n_warm;
    // result register
    logic                  r_ov,     n_ov;
    sam_pkg::t_rsp         r_rsp,    n_rsp;

    // edge memory ports
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    sam_pkg::t_edge        w_wdata;
    logic [AW-1:0]         w_raddr;
    sam_pkg::t_edge        w_rdata;

    // evaluator
    sam_pkg::t_eval_ctl    w_ctl;
    logic                  w_fire;
    logic [NODE_COUNT-1:0] w_tgt;
    logic                  w_eval;
    logic                  w_last;
    logic                  w_out_free;
    logic                  w_req_fire;
    logic [12:0]           w_slot;
    logic                  w_start_ok;
    logic                  w_grew_now;
    logic                  w_hit_now;

    sam_edge_mem #(
        .DEPTH (EDGE_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sam_edge_unit #(
        .NODE_COUNT (NODE_COUNT),
        .CALL_BITS  (CALL_BITS)
    ) u_eval (
        .i_edge (w_rdata),
        .i_set  (r_set),
        .i_ctl  (w_ctl),
        .o_fire (w_fire),
        .o_tgt  (w_tgt)
    );

    assign w_out_free  = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign i_cfg.ready = 1'b1;
    assign w_req_fire  = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

    assign w_ctl.match_mode = (r_state == S_MAT);
    assign w_ctl.call       = r_call;
    // read data comes from the address issued on the previous step: evaluate from the second step
    assign w_eval  = ((r_state == S_CLO) || (r_state == S_MAT)) && (r_idx != '0);
    assign w_last  = r_idx == (AW+1)'(EDGE_COUNT);
    assign w_raddr = (r_idx < (AW+1)'(EDGE_COUNT)) ? r_idx[AW-1:0] : '0;
    assign w_slot  = 13'(i_req.data.edge_slot);
    assign w_start_ok = 7'(r_start) < 7'(NODE_COUNT);
    assign w_grew_now = r_grew || (w_eval && w_fire);
    assign w_hit_now  = r_hit || (w_eval && w_fire);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_grew   = r_grew;
        n_phase2 = r_phase2;
        n_hit    = r_hit;
        n_set    = r_set;
        n_next   = r_next;
        n_active = r_active;
        n_cidx   = r_cidx;
        n_acc    = r_acc;
        n_count  = r_count;
        n_ecnt   = r_ecnt;
        n_viol   = r_viol;
        n_pv     = r_pv;
        n_call   = r_call;
        n_start  = r_start;
        n_warm   = r_warm;
        n_ov     = r_ov && !o_rsp.ready;
        n_rsp    = r_rsp;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = '0;

        // configuration writes; indexes beyond the list drop
        if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                sam_pkg::CFG_START_NODE: n_start = i_cfg.data.data[5:0];
                sam_pkg::CFG_WARMUP:     n_warm  = i_cfg.data.data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_CLR: begin
                // sweep the table to unused entries
                w_we = 1'b1;
                if (r_idx == (AW+1)'(EDGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_req_fire) begin
                    n_ov                = 1'b1;
                    n_rsp.verdict       = sam_pkg::V_ACK;
                    n_rsp.checked       = 1'b0;
                    n_rsp.active_count  = r_count;
                    unique case (i_req.data.req_type)
                        sam_pkg::REQ_EDGE: begin
                            if (w_slot < 13'(EDGE_COUNT)) begin
                                w_we          = 1'b1;
                                w_waddr       = w_slot[AW-1:0];
                                w_wdata.kind  = (i_req.data.edge_kind == sam_pkg::KIND_RESVD)
                                                ? sam_pkg::KIND_UNUSED
                                                : i_req.data.edge_kind;
                                w_wdata.src   = i_req.data.edge_source;
                                w_wdata.dst   = i_req.data.edge_target;
                                w_wdata.label = i_req.data.edge_label;
                            end
                        end
                        sam_pkg::REQ_START: begin
                            n_active = w_start_ok
                                ? NODE_COUNT'(1) << CW'(r_start) : '0;
                            n_count  = 7'(w_start_ok);
                            n_ecnt   = '0;
                            n_viol   = 1'b0;
                            n_rsp.active_count = 7'(w_start_ok);
                        end
                        sam_pkg::REQ_CALL: begin
                            if (r_viol) begin
                                n_rsp.verdict = sam_pkg::V_IGNORED;
                            end else if (i_req.data.at_entry) begin
                                if (r_ecnt < r_warm) begin
                                    n_ecnt = r_ecnt + 1'b1;
                                end else begin
                                    // hold the result until the walk finishes
                                    n_ov     = r_ov && !o_rsp.ready;
                                    n_call   = i_req.data.call_number;
                                    n_set    = r_active;
                                    n_idx    = '0;
                                    n_grew   = 1'b0;
                                    n_phase2 = 1'b0;
                                    n_state  = S_CLO;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLO: begin
                if (w_eval && w_fire) begin
                    n_set = r_set | w_tgt;
                end
                if (w_last) begin
                    n_idx  = '0;
                    n_grew = 1'b0;
                    if (!w_grew_now) begin
                        if (!r_phase2) begin
                            n_state = S_MAT;
                            n_next  = '0;
                            n_hit   = 1'b0;
                        end else begin
                            n_active = r_set;
                            n_cidx   = '0;
                            n_acc    = '0;
                            n_state  = S_CNT;
                        end
                    end
                end else begin
                    n_grew = w_grew_now;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_MAT: begin
                if (w_eval && w_fire) begin
                    n_next = r_next | w_tgt;
                    n_hit  = 1'b1;
                end
                if (w_last) begin
                    n_idx = '0;
                    if (w_hit_now) begin
                        n_set    = n_next;
                        n_phase2 = 1'b1;
                        n_grew   = 1'b0;
                        n_state  = S_CLO;
                    end else begin
                        // violation: the active set keeps its old value
                        n_viol  = 1'b1;
                        n_pv    = sam_pkg::V_VIOL;
                        n_state = S_DONE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CNT: begin
                // count active nodes, one per cycle
                n_acc = r_acc + 7'(r_active[r_cidx]);
                if (r_cidx == CW'(NODE_COUNT - 1)) begin
                    n_count = n_acc;
                    n_pv    = sam_pkg::V_ALLOW;
                    n_state = S_DONE;
                end else begin
                    n_cidx = r_cidx + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ov               = 1'b1;
                    n_rsp.verdict      = r_pv;
                    n_rsp.checked      = 1'b1;
                    n_rsp.active_count = r_count;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_grew   <= 1'b0;
            r_phase2 <= 1'b0;
            r_hit    <= 1'b0;
            r_active <= '0;
            r_cidx   <= '0;
            r_acc    <= '0;
            r_count  <= '0;
            r_ecnt   <= '0;
            r_viol   <= 1'b0;
            r_start  <= '0;
            r_warm   <= 8'd14;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_grew   <= n_grew;
            r_phase2 <= n_phase2;
            r_hit    <= n_hit;
            r_active <= n_active;
            r_cidx   <= n_cidx;
            r_acc    <= n_acc;
            r_count  <= n_count;
            r_ecnt   <= n_ecnt;
            r_viol   <= n_viol;
            r_start  <= n_start;
            r_warm   <= n_warm;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_set  <= n_set;
        r_next <= n_next;
        r_pv   <= n_pv;
        r_call <= n_call;
        r_rsp  <= n_rsp;
    end
endmodule

`default_nettype wire

[hw/rtl/sam_edge_mem.sv]
// ----------------------------------------------------------------------------
// sam_edge_mem - edge table storage
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_edge_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire sam_pkg::t_edge i_wdata,
    input  wire logic [AW-1:0]  i_raddr,
    output sam_pkg::t_edge      o_rdata
);
    sam_pkg::t_edge r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

[hw/rtl/sam_edge_unit.sv]
// ----------------------------------------------------------------------------
// sam_edge_unit - shared edge evaluator
// Decides whether one edge fires against a node set, for closure or match.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_edge_unit #(
    parameter int NODE_COUNT = 64,
    parameter int CALL_BITS  = 9
) (
    input  wire sam_pkg::t_edge        i_edge,
    input  wire logic [NODE_COUNT-1:0] i_set,
    input  wire sam_pkg::t_eval_ctl    i_ctl,
    output logic                       o_fire,
    output logic [NODE_COUNT-1:0]      o_tgt
);
    localparam int SW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CMP_BITS = (CALL_BITS < sam_pkg::LABEL_W) ? CALL_BITS : sam_pkg::LABEL_W;

    logic          w_src_ok;
    logic          w_dst_ok;
    logic [SW-1:0] w_src_idx;
    logic [SW-1:0] w_dst_idx;
    logic          w_src_in;
    logic          w_dst_in;
    logic          w_label_eq;

    always_comb begin
        w_src_ok   = 7'(i_edge.src) < 7'(NODE_COUNT);
        w_dst_ok   = 7'(i_edge.dst) < 7'(NODE_COUNT);
        w_src_idx  = w_src_ok ? SW'(i_edge.src) : '0;
        w_dst_idx  = w_dst_ok ? SW'(i_edge.dst) : '0;
        w_src_in   = w_src_ok && i_set[w_src_idx];
        w_dst_in   = i_set[w_dst_idx];
        w_label_eq = i_edge.label[CMP_BITS-1:0] == i_ctl.call[CMP_BITS-1:0];
        o_tgt      = NODE_COUNT'(1) << w_dst_idx;
        if (i_ctl.match_mode) begin
            o_fire = (i_edge.kind == sam_pkg::KIND_LABEL) && w_label_eq
                     && w_src_in && w_dst_ok;
        end else begin
            // epsilon step only counts when it adds a node
            o_fire = (i_edge.kind == sam_pkg::KIND_EPS) && w_src_in
                     && w_dst_ok && !w_dst_in;
        end
    end
endmodule

`default_nettype wire

[hw/rtl/sam_checker.sv]
// ----------------------------------------------------------------------------
// sam_checker - port-level checks of the syscall automaton monitor
// Watches reset behaviour and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_checker #(
    parameter int NODE_COUNT = 64
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic [1:0] i_verdict,
    input wire logic       i_checked,
    input wire logic [6:0] i_active_count
);
    // no result and no input transfer straight after reset (table clear)
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && !i_req_ready)
        else $error("activity right after reset");

    a_viol_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_verdict == sam_pkg::V_VIOL) |-> i_checked)
        else $error("violation without check");

    a_checked_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_checked |->
            (i_verdict == sam_pkg::V_ALLOW) || (i_verdict == sam_pkg::V_VIOL))
        else $error("checked result with wrong verdict");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_active_count <= 7'(NODE_COUNT))
        else $error("active count beyond node count");
endmodule

bind syscall_automaton_monitor sam_checker #(
    .NODE_COUNT (NODE_COUNT)
) u_sam_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_verdict      (o_rsp.data.verdict),
    .i_checked      (o_rsp.data.checked),
    .i_active_count (o_rsp.data.active_count)
);

`default_nettype wire
